FILE: hw/rtl/box_blur_5x5_rgb_macros.svh
// assertion macros for the 5x5 box blur block
// expects i_clk and i_rst_n in the scope of every use
`ifndef BOX_BLUR_5X5_RGB_MACROS_SVH
`define BOX_BLUR_5X5_RGB_MACROS_SVH

// condition that holds at every clock edge out of reset
`define BB_ASSERT(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// condition that must hold in the cycle after a trigger
`define BB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bblur_pkg.sv
// shared types and constants for the 5x5 box blur block
// no dependencies
package bblur_pkg;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    localparam int unsigned ADDR_W      = 12;
    localparam int unsigned ROW_W       = 12;
    localparam int unsigned HGT_W       = 13;
    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned MIN_SIZE    = 5;
    localparam int unsigned MAX_HEIGHT  = 4096;
    localparam int unsigned BORDER      = 2;
    localparam int unsigned CSUM_W      = 11;
    localparam int unsigned SUM_W       = 13;
    localparam int unsigned DIV25_SHIFT = 17;

    localparam logic [SUM_W-1:0] DIV25_MUL        = 13'd5243;
    localparam logic [8:0]       RST_IMAGE_WIDTH  = 9'd256;
    localparam logic [12:0]      RST_IMAGE_HEIGHT = 13'd256;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        t_op        op;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       out_last;
    } t_out_item;

    typedef struct packed {
        logic [8:0]  image_width;
        logic [12:0] image_height;
    } t_cfg;

    // one classified request handed from front to back
    typedef struct packed {
        t_op              kind;
        logic             emit;
        logic             interior;
        logic             last;
        logic [1:0]       slot;
        logic [ADDR_W-1:0] addr;
        t_rgb             pix;
    } t_cmd;

endpackage

FILE: hw/rtl/bblur_front.sv
// front part of the box blur: accepts requests, tracks positions, classifies
// depends on bblur_pkg and box_blur_5x5_rgb_macros.svh
`include "box_blur_5x5_rgb_macros.svh"

module bblur_front
    import bblur_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_restart,
    input  logic     i_valid,
    input  t_in_item i_data,
    output logic     o_stall,
    output logic     o_push,
    output t_cmd     o_cmd,
    input  logic     i_full
);

    localparam int unsigned XW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CX = CW + 1;
    localparam int unsigned PW = CW + 2;

    logic [CW-1:0]    eff_w;
    logic [HGT_W-1:0] eff_h;
    logic [PW-1:0]    lat;

    logic [XW-1:0]    r_in_col, n_in_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [XW-1:0]    r_ocol, n_ocol;
    logic [ROW_W-1:0] r_orow, n_orow;
    logic [PW-1:0]    r_pend, n_pend;

    logic             accept;
    logic             is_flush;
    logic             pin_zero;
    logic             q_nonzero;
    logic             drop;
    logic             flush_go;
    logic [XW-1:0]    q_col;
    logic [ROW_W-1:0] q_row;
    logic [PW-1:0]    pend_e;
    logic             emit_pix;
    logic             q_last;
    logic             interior;
    logic [CW-1:0]    q_col_inc;
    logic [XW-1:0]    q_col_next;
    logic [ROW_W-1:0] q_row_next;
    logic [CW-1:0]    in_col_inc;
    logic [HGT_W-1:0] in_row_inc;

    // clamp the geometry registers to the supported range
    always_comb begin
        if (i_cfg.image_width < 9'(MIN_SIZE)) begin
            eff_w = CW'(MIN_SIZE);
        end else if (32'(i_cfg.image_width) > MAX_WIDTH) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(i_cfg.image_width);
        end
        if (i_cfg.image_height < HGT_W'(MIN_SIZE)) begin
            eff_h = HGT_W'(MIN_SIZE);
        end else if (i_cfg.image_height > HGT_W'(MAX_HEIGHT)) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end else begin
            eff_h = i_cfg.image_height;
        end
    end

    assign lat = (PW'(eff_w) << 1) + PW'(BORDER);

    assign accept    = i_valid && !i_full;
    assign is_flush  = (i_data.op == OP_FLUSH);
    assign pin_zero  = (r_in_col == '0) && (r_in_row == '0);
    assign q_nonzero = (r_ocol != '0) || (r_orow != '0);
    assign flush_go  = pin_zero && q_nonzero;

    // new pixel while a drain is only partly done drops the old tail
    assign drop     = !is_flush && flush_go && (r_pend < lat);
    assign q_col    = drop ? '0 : r_ocol;
    assign q_row    = drop ? '0 : r_orow;
    assign pend_e   = drop ? '0 : r_pend;
    assign emit_pix = (pend_e >= lat);

    assign q_last = (CW'(q_col) == eff_w - CW'(1)) &&
                    (HGT_W'(q_row) == eff_h - HGT_W'(1));

    assign interior = (q_row >= ROW_W'(BORDER)) &&
                      ((HGT_W'(q_row) + HGT_W'(BORDER)) < eff_h) &&
                      (q_col >= XW'(BORDER)) &&
                      ((CX'(q_col) + CX'(BORDER)) < CX'(eff_w));

    // next output position
    always_comb begin
        q_col_inc = CW'(q_col) + CW'(1);
        if (q_last) begin
            q_col_next = '0;
            q_row_next = '0;
        end else if (q_col_inc == eff_w) begin
            q_col_next = '0;
            q_row_next = q_row + ROW_W'(1);
        end else begin
            q_col_next = XW'(q_col_inc);
            q_row_next = q_row;
        end
    end

    assign in_col_inc = CW'(r_in_col) + CW'(1);
    assign in_row_inc = HGT_W'(r_in_row) + HGT_W'(1);

    always_comb begin
        o_cmd.kind     = i_data.op;
        o_cmd.emit     = is_flush ? 1'b1 : emit_pix;
        o_cmd.interior = is_flush ? 1'b0 : interior;
        o_cmd.last     = q_last;
        o_cmd.slot     = r_orow[1:0] - eff_h[1:0];
        o_cmd.addr     = is_flush ? ADDR_W'(r_ocol) : ADDR_W'(r_in_col);
        o_cmd.pix.red   = i_data.in_red;
        o_cmd.pix.green = i_data.in_green;
        o_cmd.pix.blue  = i_data.in_blue;
    end

    // flush outside a drain (input mid-frame or nothing owed) is taken and dropped here
    assign o_push  = accept && (!is_flush || flush_go);
    assign o_stall = i_full;

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_ocol   = r_ocol;
        n_orow   = r_orow;
        n_pend   = r_pend;
        if (i_restart) begin
            n_in_col = '0;
            n_in_row = '0;
            n_ocol   = '0;
            n_orow   = '0;
            n_pend   = '0;
        end else if (accept) begin
            if (is_flush) begin
                if (flush_go) begin
                    n_ocol = q_col_next;
                    n_orow = q_row_next;
                    n_pend = r_pend - PW'(1);
                end
            end else begin
                if (in_col_inc >= eff_w) begin
                    n_in_col = '0;
                    n_in_row = (in_row_inc >= eff_h) ? '0 : ROW_W'(in_row_inc);
                end else begin
                    n_in_col = XW'(in_col_inc);
                end
                n_ocol = emit_pix ? q_col_next : q_col;
                n_orow = emit_pix ? q_row_next : q_row;
                n_pend = pend_e + PW'(1) - PW'(emit_pix);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
            r_pend   <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_ocol   <= n_ocol;
            r_orow   <= n_orow;
            r_pend   <= n_pend;
        end
    end

    `BB_ASSERT(a_pend_bound, r_pend <= lat, "pending count above window latency")

endmodule

FILE: hw/rtl/bblur_fifo.sv
// short command queue between front and back of the box blur
// depends on bblur_pkg and box_blur_5x5_rgb_macros.svh
`include "box_blur_5x5_rgb_macros.svh"

module bblur_fifo
    import bblur_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    t_cmd             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `BB_ASSERT(a_no_overflow, !(i_push && o_full), "push into full queue")
    `BB_ASSERT(a_no_underflow, !(i_pop && o_empty), "pop from empty queue")

endmodule

FILE: hw/rtl/bblur_back.sv
// back part of the box blur: line memory, window sums, divide by 25, output register
// depends on bblur_pkg and box_blur_5x5_rgb_macros.svh
`include "box_blur_5x5_rgb_macros.svh"

module bblur_back
    import bblur_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    localparam int unsigned XW = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } t_csum;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_bsum;

    typedef struct packed {
        t_op  kind;
        logic emit;
        logic interior;
        logic last;
        t_rgb pass;
    } t_stage;

    // four previous rows per column, row 0 oldest
    t_rgb [3:0] r_line [MAX_WIDTH];
    t_rgb [3:0] r_rd;

    t_cmd      r_s1;
    logic      r_s1_valid;
    t_stage    r_s2;
    logic      r_s2_valid;
    t_stage    r_s3;
    logic      r_s3_valid;
    t_bsum     r_tot;
    t_out_item r_out;
    logic      r_out_valid;

    // window state: column sums and the centre row history
    t_csum r_cs [5];
    t_rgb  r_mid0;
    t_rgb  r_mid1;

    logic               adv;
    logic               pop;
    logic               s1_pix_go;
    t_csum              cs;
    t_stage             s2_in;
    t_bsum              tot;
    logic [2*SUM_W-1:0] prod_r;
    logic [2*SUM_W-1:0] prod_g;
    logic [2*SUM_W-1:0] prod_b;

    assign adv       = !r_out_valid || !i_stall;
    assign pop       = adv && !i_empty;
    assign s1_pix_go = adv && r_s1_valid && (r_s1.kind == OP_PIXEL);
    assign o_pop     = pop;

    // line memory: read on pop, shifted word written back when the pixel advances out of stage 1
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd <= r_line[i_cmd.addr[XW-1:0]];
        end
        if (s1_pix_go) begin
            r_line[r_s1.addr[XW-1:0]] <= {r_s1.pix, r_rd[3], r_rd[2], r_rd[1]};
        end
    end

    // new window column sum
    always_comb begin
        cs.red   = CSUM_W'(r_s1.pix.red);
        cs.green = CSUM_W'(r_s1.pix.green);
        cs.blue  = CSUM_W'(r_s1.pix.blue);
        for (int r = 0; r < 4; r++) begin
            cs.red   = cs.red + CSUM_W'(r_rd[r].red);
            cs.green = cs.green + CSUM_W'(r_rd[r].green);
            cs.blue  = cs.blue + CSUM_W'(r_rd[r].blue);
        end
    end

    always_comb begin
        s2_in.kind     = r_s1.kind;
        s2_in.emit     = r_s1.emit;
        s2_in.interior = r_s1.interior;
        s2_in.last     = r_s1.last;
        s2_in.pass     = (r_s1.kind == OP_FLUSH) ? r_rd[r_s1.slot] : r_mid1;
    end

    // window total over the five column sums
    always_comb begin
        tot = '0;
        for (int k = 0; k < 5; k++) begin
            tot.red   = tot.red + SUM_W'(r_cs[k].red);
            tot.green = tot.green + SUM_W'(r_cs[k].green);
            tot.blue  = tot.blue + SUM_W'(r_cs[k].blue);
        end
    end

    // divide by 25 through the reciprocal, exact for totals below 6376
    assign prod_r = (2*SUM_W)'(r_tot.red) * (2*SUM_W)'(DIV25_MUL);
    assign prod_g = (2*SUM_W)'(r_tot.green) * (2*SUM_W)'(DIV25_MUL);
    assign prod_b = (2*SUM_W)'(r_tot.blue) * (2*SUM_W)'(DIV25_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= !i_empty;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid && r_s3.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1  <= i_cmd;
            r_s2  <= s2_in;
            r_s3  <= r_s2;
            r_tot <= tot;
        end
        if (s1_pix_go) begin
            r_cs[0] <= cs;
            for (int k = 1; k < 5; k++) begin
                r_cs[k] <= r_cs[k-1];
            end
            r_mid0 <= r_rd[2];
            r_mid1 <= r_mid0;
        end
        if (adv && r_s3_valid && r_s3.emit) begin
            r_out.out_red   <= r_s3.interior ? prod_r[DIV25_SHIFT +: 8] : r_s3.pass.red;
            r_out.out_green <= r_s3.interior ? prod_g[DIV25_SHIFT +: 8] : r_s3.pass.green;
            r_out.out_blue  <= r_s3.interior ? prod_b[DIV25_SHIFT +: 8] : r_s3.pass.blue;
            r_out.out_last  <= r_s3.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `BB_ASSERT(a_flush_no_sum, !(r_s1_valid && r_s1.kind == OP_FLUSH && r_s1.interior), "flush marked interior")
    `BB_ASSERT_NEXT(a_result_loaded, adv && r_s3_valid && r_s3.emit, r_out_valid, "result lost at output")

endmodule

FILE: hw/rtl/box_blur_5x5_rgb.sv
// top level of the 5x5 rgb box blur: apb registers, front, queue and back
// depends on bblur_pkg, bblur_front, bblur_fifo and bblur_back
//
// channel  role          handshake                      payload
// in       pixel/flush   i_in_valid / o_in_stall        i_in_data (t_in_item)
// out      result        o_out_valid / i_out_stall      o_out_data (t_out_item)
// cfg      apb write     psel penable pwrite pready     pwdata at paddr
//
// one request per clock while the output is not stalled; the line memory takes one read
// and one write-back a cycle; a registered result leaves 2*width+2 pixels after its pixel
// sync reset clears positions, queue and pipeline valids, geometry goes to 256 x 256
// line memory is never cleared: only rows written in the frame feed results
// out stall freezes the back pipeline, the 4-entry queue then fills and raises o_in_stall

module box_blur_5x5_rgb
    import bblur_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    // result stream
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_cfg     r_cfg;
    logic     cfg_wr;
    t_reg_idx reg_idx;

    logic fifo_push;
    t_cmd fifo_wdata;
    logic fifo_full;
    logic fifo_pop;
    t_cmd fifo_rdata;
    logic fifo_empty;

    // registers sit at byte offsets 0 and 4, decoded by address bit 2
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= pwdata[8:0];
                end
                REG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= pwdata[12:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH: begin
                prdata = 32'(r_cfg.image_width);
            end
            REG_IMAGE_HEIGHT: begin
                prdata = 32'(r_cfg.image_height);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // front: positions, pending count, drain and drop decisions
    // any register write restarts the frame
    bblur_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (cfg_wr),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .o_stall   (o_in_stall),
        .o_push    (fifo_push),
        .o_cmd     (fifo_wdata),
        .i_full    (fifo_full)
    );

    // queue lets the input side keep going while the result side stalls
    bblur_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (fifo_wdata),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_data  (fifo_rdata),
        .o_empty (fifo_empty)
    );

    // back: line memory, window column sums, total, divide, output register
    bblur_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (fifo_empty),
        .i_cmd   (fifo_rdata),
        .o_pop   (fifo_pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

FILE: test/box_blur_5x5_rgb_tb.sv
// self-checking testbench for the 5x5 rgb box blur: random and directed pixel streams
// predicts every result in-line and checks it field by field; depends on bblur_pkg
`timescale 1ns / 100ps

module box_blur_5x5_rgb_tb;
    import bblur_pkg::*;

    localparam int unsigned LINE_W      = 256;     // line store depth per row in the dut
    localparam int unsigned KERNEL_AREA = 25;
    localparam int unsigned SETTLE_CYC  = 20;      // well past the back pipeline
    localparam int unsigned CYCLE_LIMIT = 300000;

    // clock, reset and dut-facing signals, the driven ones known from time zero
    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_item    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;

    // stimulus and checking state
    t_in_item    pending_req [$];
    t_out_item   expected_px [$];
    t_out_item   want;
    bit          in_taken;
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned err_count;
    int unsigned results_seen;
    int unsigned cycle_count;
    int unsigned plan_pos;       // position in frame of the next pixel put in the queue

    // predictor state: line rows, window, positions and geometry registers
    t_rgb        line_mem [4*LINE_W] = '{default: '0};
    t_rgb        win [5][5]          = '{default: '{default: '0}};
    int unsigned col_in;
    int unsigned row_in;
    int unsigned out_pos;
    logic [8:0]  geo_w = RST_IMAGE_WIDTH;
    logic [12:0] geo_h = RST_IMAGE_HEIGHT;

    box_blur_5x5_rgb #(
        .MAX_WIDTH (LINE_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // geometry in use: registers clamped to the supported range
    function automatic int unsigned eff_width();
        if (geo_w < MIN_SIZE) return MIN_SIZE;
        if (geo_w > LINE_W) return LINE_W;
        return 32'(geo_w);
    endfunction

    function automatic int unsigned eff_height();
        if (geo_h < MIN_SIZE) return MIN_SIZE;
        if (geo_h > MAX_HEIGHT) return MAX_HEIGHT;
        return 32'(geo_h);
    endfunction

    // mean of the 25 window pixels per channel, rounded down
    function automatic t_rgb window_mean();
        int unsigned sr, sg, sb;
        int r, c;
        t_rgb m;
        sr = 0;
        sg = 0;
        sb = 0;
        for (r = 0; r < 5; r++) begin
            for (c = 0; c < 5; c++) begin
                sr += 32'(win[r][c].red);
                sg += 32'(win[r][c].green);
                sb += 32'(win[r][c].blue);
            end
        end
        m.red   = 8'(sr / KERNEL_AREA);
        m.green = 8'(sg / KERNEL_AREA);
        m.blue  = 8'(sb / KERNEL_AREA);
        return m;
    endfunction

    // advance the blur by one accepted request and queue the pixel it releases, if any
    task automatic blur_step(input t_in_item it);
        int unsigned w, h, n, lat, pin, q, pend, orow, ocol, col;
        int r, c;
        t_rgb pix, center;
        t_rgb a [4];
        t_out_item res;
        w    = eff_width();
        h    = eff_height();
        n    = w * h;
        lat  = BORDER * w + BORDER;
        pin  = row_in * w + col_in;
        q    = out_pos;
        pend = (pin >= q) ? pin - q : pin + n - q;

        if (it.op == OP_FLUSH) begin
            // a flush only counts once the whole frame is in and outputs are owed
            if (pin == 0 && q != 0) begin
                orow = q / w;
                ocol = q % w;
                center = line_mem[((orow + 4 - h) & 3) * LINE_W + ocol];
                res.out_red   = center.red;
                res.out_green = center.green;
                res.out_blue  = center.blue;
                res.out_last  = (q + 1 == n);
                expected_px.push_back(res);
                out_pos = (q + 1 == n) ? 0 : q + 1;
            end
            return;
        end

        // new pixel while a short drain is still pending: drop the old frame's tail
        if (pin == 0 && q != 0 && pend < lat) begin
            q    = 0;
            pend = 0;
        end

        pix = {it.in_red, it.in_green, it.in_blue};
        col = col_in % LINE_W;
        for (r = 0; r < 4; r++) a[r] = line_mem[r * LINE_W + col];
        for (r = 0; r < 3; r++) line_mem[r * LINE_W + col] = a[r + 1];
        line_mem[3 * LINE_W + col] = pix;

        for (r = 0; r < 5; r++) begin
            for (c = 0; c < 4; c++) win[r][c] = win[r][c + 1];
        end
        for (r = 0; r < 4; r++) win[r][4] = a[r];
        win[4][4] = pix;

        if (pend >= lat) begin
            orow = q / w;
            ocol = q % w;
            // border pixels pass through, interior pixels get the box mean
            if (orow >= BORDER && orow + BORDER < h && ocol >= BORDER && ocol + BORDER < w) begin
                center = window_mean();
            end else begin
                center = win[2][2];
            end
            res.out_red   = center.red;
            res.out_green = center.green;
            res.out_blue  = center.blue;
            res.out_last  = (q + 1 == n);
            expected_px.push_back(res);
            q = (q + 1 == n) ? 0 : q + 1;
        end

        col_in++;
        if (col_in >= w) begin
            col_in = 0;
            row_in++;
            if (row_in >= h) row_in = 0;
        end
        out_pos = q;
    endtask

    // channel value leaning toward the extremes
    function automatic logic [7:0] chan_value();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_item new_request(input t_op op);
        t_in_item it;
        it.op       = op;
        it.in_red   = chan_value();
        it.in_green = chan_value();
        it.in_blue  = chan_value();
        return it;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    // apb write: setup then access, register taken at the edge with pready high
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // any register write restarts the frame, line rows and window are kept
        case (idx)
            REG_IMAGE_WIDTH:  geo_w = data[8:0];
            REG_IMAGE_HEIGHT: geo_h = data[12:0];
            default: ;
        endcase
        col_in   = 0;
        row_in   = 0;
        out_pos  = 0;
        plan_pos = 0;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_geometry(input logic [31:0] wv, input logic [31:0] hv);
        apb_write(REG_IMAGE_WIDTH, wv);
        apb_write(REG_IMAGE_HEIGHT, hv);
    endtask

    // wait until every queued request is taken and every result is back,
    // then give the pipeline time to finish requests that release nothing
    // checked at the rising edge, where the driver outputs are settled
    task automatic settle();
        do @(posedge i_clk);
        while (pending_req.size() != 0 || in_valid || expected_px.size() != 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // mostly whole frames with random tails (full drain, short drain, back to back),
    // the rest partial runs and stray flushes
    task automatic gen_traffic(input int unsigned pixels);
        int unsigned w, n, sent, k, f, pick;
        w    = eff_width();
        n    = w * eff_height();
        sent = 0;
        while (sent < pixels) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                k = n - plan_pos;
            end else if (pick < 9) begin
                k = $urandom_range(1, n - 1);
            end else begin
                k = 0;
            end
            repeat (k) pending_req.push_back(new_request(OP_PIXEL));
            sent    += k;
            plan_pos = (plan_pos + k) % n;
            if (pick < 7) begin
                case ($urandom_range(0, 3))
                    1: f = 2 * w + 2 + $urandom_range(0, 2);
                    2: f = $urandom_range(1, 2 * w + 1);
                    default: f = 0;
                endcase
            end else begin
                f = $urandom_range((pick == 9) ? 1 : 0, 2);
            end
            repeat (f) pending_req.push_back(new_request(OP_FLUSH));
        end
    endtask

    // one random-geometry phase; optionally the sender holds off halfway until all is back
    task automatic run_phase(input int unsigned sidle, input int unsigned ostall,
                             input int unsigned pixels, input bit hold);
        send_idle_pct = sidle;
        stall_pct     = ostall;
        // junk in the upper bits, raw sizes below the minimum now and then
        set_geometry(($urandom() << 9) | 32'($urandom_range(0, 12)),
                     ($urandom() << 13) | 32'($urandom_range(0, 9)));
        if (hold) begin
            gen_traffic(pixels / 2);
            settle();
            gen_traffic(pixels / 2);
        end else begin
            gen_traffic(pixels);
        end
        settle();
    endtask

    // request driver: presents at the falling edge, holds while stalled
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_taken = 1'b0;
        end else if (!in_valid || in_taken) begin
            in_taken = 1'b0;
            if (pending_req.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= pending_req.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // request accepted: run the predictor on it
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !in_stall) begin
            blur_step(in_data);
            in_taken = 1'b1;
        end
    end

    // result monitor: each taken result against the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_px.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                want = expected_px.pop_front();
                if (out_data.out_red !== want.out_red)
                    report_mismatch($sformatf("result %0d red %02h, expected %02h",
                                              results_seen, out_data.out_red, want.out_red));
                if (out_data.out_green !== want.out_green)
                    report_mismatch($sformatf("result %0d green %02h, expected %02h",
                                              results_seen, out_data.out_green,
                                              want.out_green));
                if (out_data.out_blue !== want.out_blue)
                    report_mismatch($sformatf("result %0d blue %02h, expected %02h",
                                              results_seen, out_data.out_blue, want.out_blue));
                if (out_data.out_last !== want.out_last)
                    report_mismatch($sformatf("result %0d last %b, expected %b",
                                              results_seen, out_data.out_last, want.out_last));
            end
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_in_item d;
        int unsigned i;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: sizes below the minimum clamp to a 5x5 frame
        set_geometry(32'd3, 32'd0);
        // flush with nothing owed is ignored
        pending_req.push_back(new_request(OP_FLUSH));
        for (i = 0; i < 25; i++) begin
            d.op       = OP_PIXEL;
            d.in_red   = 8'(i * 10);
            d.in_green = 8'(255 - i * 10);
            d.in_blue  = 8'(i * 37);
            if (i == 0) begin
                d.in_red   = 8'hFF;
                d.in_green = 8'hFF;
                d.in_blue  = 8'hFF;
            end else if (i == 24) begin
                d.in_red   = 8'h00;
                d.in_green = 8'h00;
                d.in_blue  = 8'h00;
            end
            pending_req.push_back(d);
            // flush in the middle of the frame is ignored
            if (i == 7) pending_req.push_back(new_request(OP_FLUSH));
        end
        // drain the 12 owed pixels, the last one flagged, then one flush too many
        repeat (13) pending_req.push_back(new_request(OP_FLUSH));
        settle();

        // random phases over the idle and stall mixes
        run_phase(0, 0, 30, 1'b0);
        run_phase(50, 0, 30, 1'b1);
        run_phase(0, 50, 30, 1'b0);
        run_phase(33, 33, 30, 1'b0);

        // widest and tallest: raw values beyond range clamp to 256 x 4096,
        // just past the priming length so a few results come out mid-frame
        set_geometry(32'h1FF, 32'h1FFF);
        for (i = 0; i < 530; i++) begin
            pending_req.push_back(new_request(OP_PIXEL));
            if (i % 100 == 50) pending_req.push_back(new_request(OP_FLUSH));
        end
        settle();

        // restart from a half-done frame into small geometry
        run_phase(33, 33, 30, 1'b0);

        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bblur_pkg.sv
hw/rtl/bblur_front.sv
hw/rtl/bblur_fifo.sv
hw/rtl/bblur_back.sv
hw/rtl/box_blur_5x5_rgb.sv
test/box_blur_5x5_rgb_tb.sv
